[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the dual-channel FIR block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/dcfir_pkg.sv]
// Package with beat types, sizes and the coefficient table of the FIR block
package dcfir_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned DcWidth     = 16;
  localparam int unsigned TapCountDef = 51;
  localparam int unsigned CoefCount   = 51;
  localparam int unsigned CoefWidth   = 12;
  localparam int unsigned CoefIdxW    = $clog2(CoefCount);
  localparam int unsigned TapArgW     = 8;
  localparam int unsigned FracBits    = 15;

  typedef struct packed {
    logic signed [SampleWidth-1:0] red_ac_sample;
    logic signed [SampleWidth-1:0] ir_ac_sample;
    logic        [DcWidth-1:0]     red_dc_level;
    logic        [DcWidth-1:0]     ir_dc_level;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] red_filtered;
    logic signed [SampleWidth-1:0] ir_filtered;
    logic        [DcWidth-1:0]     red_dc_out;
    logic        [DcWidth-1:0]     ir_dc_out;
  } out_beat_t;

  // Symmetric low-pass taps in Q1.15, summing to 32768
  localparam logic [CoefWidth-1:0] CoefTable [CoefCount] = '{
    12'd0,    12'd5,    12'd13,   12'd23,   12'd39,   12'd61,   12'd91,
    12'd131,  12'd180,  12'd240,  12'd312,  12'd393,  12'd485,  12'd585,
    12'd691,  12'd801,  12'd914,  12'd1025, 12'd1133, 12'd1234, 12'd1325,
    12'd1403, 12'd1467, 12'd1514, 12'd1543, 12'd1552, 12'd1543, 12'd1514,
    12'd1467, 12'd1403, 12'd1325, 12'd1234, 12'd1133, 12'd1025, 12'd914,
    12'd801,  12'd691,  12'd585,  12'd485,  12'd393,  12'd312,  12'd240,
    12'd180,  12'd131,  12'd91,   12'd61,   12'd39,   12'd23,   12'd13,
    12'd5,    12'd0
  };

  // Look up one tap weight; taps past the table weigh zero
  function automatic logic [CoefWidth-1:0] coef_at(input logic [TapArgW-1:0] idx);
    logic [CoefWidth-1:0] c;
    c = '0;
    if (idx < TapArgW'(CoefCount)) begin
      c = CoefTable[idx[CoefIdxW-1:0]];
    end
    return c;
  endfunction

endpackage

[rtl/dcfir_stream_if.sv]
// Valid/ready stream interface carrying one payload beat
interface dcfir_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/dcfir_ram.sv]
// Generic RAM with one write port and one registered read port
module dcfir_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dual_channel_fir_lowpass.sv]
// After an input beat is taken the block steps through the run, drain and finish states
// and then loads the output register; it takes no new input beat until it is idle again,
// with one shared delay-line RAM read port feeding one multiply-accumulate per channel per tap.
// The output register holds a finished beat while the next input beat is taken.
// Reset clears control state; taps not yet written since reset read as zero via a fill count.
// Top level: two-channel FIR low-pass filter over a shared delay-line RAM
module dual_channel_fir_lowpass #(
  parameter int unsigned TapCount = dcfir_pkg::TapCountDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  dcfir_stream_if.sink         in_i,
  dcfir_stream_if.source       out_o
);

  import dcfir_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AddrW  = $clog2(TapCount);
  localparam int unsigned FillW  = $clog2(TapCount + 1);
  localparam int unsigned RamW   = 2 * SampleWidth;
  localparam int unsigned ProdW  = SampleWidth + CoefWidth + 1;
  localparam int unsigned AccW   = ProdW + $clog2(TapCount) + 1;
  localparam logic [AddrW-1:0] LastTap = AddrW'(TapCount - 1);
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(2 ** (FracBits - 1));
  localparam logic signed [AccW-1:0] SatMax    = AccW'(2 ** (SampleWidth - 1) - 1);
  localparam logic signed [AccW-1:0] SatMin    = ~SatMax;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain,
    StFinish
  } st_e;

  st_e              state_q, state_d;
  logic [AddrW-1:0] wr_pos_q, wr_pos_d;
  logic [AddrW-1:0] rd_addr_q, rd_addr_d;
  logic [AddrW-1:0] tap_q, tap_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_data_q, out_data_d;

  logic             in_fire;
  logic             issue;
  logic [RamW-1:0]  ram_rdata;

  logic             s1_vld_q, s1_last_q, s2_vld_q, s2_last_q;
  logic [AddrW-1:0] s1_tap_q;
  logic             s1_live;

  logic signed [SampleWidth-1:0] ram_red, ram_ir;
  logic signed [CoefWidth:0]     coef_s;
  logic signed [ProdW-1:0]       prod_red_d, prod_ir_d, prod_red_q, prod_ir_q;
  logic signed [AccW-1:0]        acc_red_q, acc_ir_q;
  logic [DcWidth-1:0]            red_dc_q, ir_dc_q;

  // Round half up, drop the fraction and clamp to the sample range
  function automatic logic signed [SampleWidth-1:0] round_sat(
    input logic signed [AccW-1:0] acc
  );
    logic signed [AccW-1:0] shf;
    logic signed [AccW-1:0] lim;
    shf = (acc + RoundHalf) >>> FracBits;
    lim = shf;
    if (shf > SatMax) begin
      lim = SatMax;
    end else if (shf < SatMin) begin
      lim = SatMin;
    end
    return lim[SampleWidth-1:0];
  endfunction

  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && (state_q == StIdle);
  assign issue       = (state_q == StRun);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Delay lines of both channels share one entry per time step
  dcfir_ram #(
    .Width (RamW),
    .Depth (TapCount)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (wr_pos_q),
    .wdata_i ({in_i.data.red_ac_sample, in_i.data.ir_ac_sample}),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Sequence write, tap reads, drain and result hand-off
  always_comb begin
    state_d     = state_q;
    wr_pos_d    = wr_pos_q;
    rd_addr_d   = rd_addr_q;
    tap_d       = tap_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d   = StRun;
          tap_d     = '0;
          rd_addr_d = wr_pos_q;
          wr_pos_d  = (wr_pos_q == LastTap) ? '0 : wr_pos_q + 1'b1;
          if (fill_q < FillW'(TapCount)) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      StRun: begin
        tap_d     = tap_q + 1'b1;
        rd_addr_d = (rd_addr_q == '0) ? LastTap : rd_addr_q - 1'b1;
        if (tap_q == LastTap) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (s2_vld_q && s2_last_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d             = 1'b1;
          out_data_d.red_filtered = round_sat(acc_red_q);
          out_data_d.ir_filtered  = round_sat(acc_ir_q);
          out_data_d.red_dc_out   = red_dc_q;
          out_data_d.ir_dc_out    = ir_dc_q;
          state_d                 = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state, counters and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wr_pos_q    <= '0;
      rd_addr_q   <= '0;
      tap_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      wr_pos_q    <= wr_pos_d;
      rd_addr_q   <= rd_addr_d;
      tap_q       <= tap_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Advance the pipeline valid and last-tap flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      s1_tap_q  <= '0;
    end else begin
      s1_vld_q  <= issue;
      s1_last_q <= issue && (tap_q == LastTap);
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      s1_tap_q  <= tap_q;
    end
  end

  // Drop taps older than the samples written since reset
  assign s1_live    = s1_vld_q && (FillW'(s1_tap_q) < fill_q);
  assign ram_red    = $signed(ram_rdata[RamW-1:SampleWidth]);
  assign ram_ir     = $signed(ram_rdata[SampleWidth-1:0]);
  assign coef_s     = $signed({1'b0, coef_at(TapArgW'(s1_tap_q))});
  assign prod_red_d = ram_red * coef_s;
  assign prod_ir_d  = ram_ir * coef_s;

  // Register products, accumulate, and capture the DC levels
  always_ff @(posedge clk_i) begin
    prod_red_q <= s1_live ? prod_red_d : '0;
    prod_ir_q  <= s1_live ? prod_ir_d : '0;
    if (in_fire) begin
      acc_red_q <= '0;
      acc_ir_q  <= '0;
      red_dc_q  <= in_i.data.red_dc_level;
      ir_dc_q   <= in_i.data.ir_dc_level;
    end else if (s2_vld_q) begin
      acc_red_q <= acc_red_q + AccW'(prod_red_q);
      acc_ir_q  <= acc_ir_q + AccW'(prod_ir_q);
    end
  end

  `ASSERT_IMPLY(a_out_from_finish, $rose(out_valid_q), $past(state_q == StFinish),
                "output beat raised outside the finish state")
  `ASSERT_IMPLY(a_last_in_drain, s2_vld_q && s2_last_q, state_q == StDrain,
                "last product arrived outside the drain state")
  `ASSERT_ALWAYS(a_fill_bound, fill_q <= FillW'(TapCount),
                 "fill count exceeds the tap count")
  `ASSERT_IMPLY(a_no_read_when_idle, state_q == StIdle, !s1_vld_q && !s2_vld_q,
                "tap pipeline busy while idle")

endmodule

[dv/tb.sv]
// Self-checking testbench for the dual-channel 51-tap FIR low-pass filter
`timescale 1ns / 100ps

module tb;
  import dcfir_pkg::*;

  localparam int TAPS         = 51;
  localparam int MAX_GAP      = 10;
  localparam int RANDOM_BEATS = 1600;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;

  // Q1.15 tap weights, newest sample first
  localparam int TAP_WEIGHT [TAPS] = '{
    0, 5, 13, 23, 39, 61, 91, 131, 180, 240, 312, 393, 485,
    585, 691, 801, 914, 1025, 1133, 1234, 1325, 1403, 1467, 1514, 1543,
    1552,
    1543, 1514, 1467, 1403, 1325, 1234, 1133, 1025, 914, 801, 691, 585,
    485, 393, 312, 240, 180, 131, 91, 61, 39, 23, 13, 5, 0
  };

  // Sample shapes for the random segments
  typedef enum int {
    SHAPE_FULL,
    SHAPE_HOLD_MAX,
    SHAPE_HOLD_MIN,
    SHAPE_TOGGLE,
    SHAPE_SMALL,
    SHAPE_STEP
  } shape_e;
  localparam int SHAPE_COUNT = 6;

  typedef struct {
    in_beat_t                      beat;
    bit                            typed;
    logic signed [SampleWidth-1:0] red_want;
    logic signed [SampleWidth-1:0] ir_want;
  } vector_t;

  logic clk_i  = 1'b0;
  logic rst_ni;

  dcfir_stream_if #(.payload_t(in_beat_t))  in_if ();
  dcfir_stream_if #(.payload_t(out_beat_t)) out_if ();

  dual_channel_fir_lowpass u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Filter state mirrored from the block
  logic signed [SampleWidth-1:0] red_line [TAPS];
  logic signed [SampleWidth-1:0] ir_line  [TAPS];
  int                            wr_pos;

  out_beat_t filtered_due [$];
  vector_t   vectors [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        tx_calm;

  always #6 clk_i = ~clk_i;

  // Round Q1.15 to nearest, half toward plus infinity, then clamp
  function automatic logic signed [SampleWidth-1:0] round_q15(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> FracBits;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SampleWidth-1:0];
  endfunction

  // Write both samples into the delay lines and form one filtered beat
  function automatic out_beat_t filter_beat(in_beat_t b);
    out_beat_t r;
    longint    red_acc;
    longint    ir_acc;
    int        pos;
    red_line[wr_pos] = b.red_ac_sample;
    ir_line[wr_pos]  = b.ir_ac_sample;
    red_acc = 0;
    ir_acc  = 0;
    for (int i = 0; i < TAPS; i++) begin
      pos = (wr_pos + TAPS - i) % TAPS;
      red_acc += TAP_WEIGHT[i] * longint'(red_line[pos]);
      ir_acc  += TAP_WEIGHT[i] * longint'(ir_line[pos]);
    end
    r.red_filtered = round_q15(red_acc);
    r.ir_filtered  = round_q15(ir_acc);
    r.red_dc_out   = b.red_dc_level;
    r.ir_dc_out    = b.ir_dc_level;
    wr_pos = (wr_pos + 1) % TAPS;
    return r;
  endfunction

  function automatic logic signed [SampleWidth-1:0] pick_sample(shape_e s, int n, bit mirror);
    logic signed [SampleWidth-1:0] v;
    case (s)
      SHAPE_HOLD_MAX: v = mirror ? 16'sh8000 : 16'sh7FFF;
      SHAPE_HOLD_MIN: v = mirror ? 16'sh7FFF : 16'sh8000;
      SHAPE_TOGGLE:   v = (n[0] ^ mirror) ? 16'sh7FFF : 16'sh8000;
      SHAPE_SMALL:    v = 16'(int'($urandom_range(0, 15)) - 8);
      SHAPE_STEP:     v = 16'((((n / 17) % 2 == 1) ^ mirror) ?
                          20000 + int'($urandom_range(0, 255)) :
                          -20000 - int'($urandom_range(0, 255)));
      default:        v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic add_vector(int red, int ir, int rdc, int idc, bit typed,
                            int red_want, int ir_want);
    vector_t v;
    v.beat.red_ac_sample = 16'(red);
    v.beat.ir_ac_sample  = 16'(ir);
    v.beat.red_dc_level  = 16'(rdc);
    v.beat.ir_dc_level   = 16'(idc);
    v.typed              = typed;
    v.red_want           = 16'(red_want);
    v.ir_want            = 16'(ir_want);
    vectors.push_back(v);
  endtask

  // Present one beat after a random gap (none while calm) and hold it until taken
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Stimulus: reset, directed table, random segments, drain
  initial begin : stimulus
    in_beat_t  b;
    out_beat_t guess;
    shape_e    shape;
    int        seg_left;
    int        sent;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    tx_calm     = 1'b0;
    wr_pos      = 0;
    for (int i = 0; i < TAPS; i++) begin
      red_line[i] = '0;
      ir_line[i]  = '0;
    end

    // First beat after reset meets only the zero-weight newest tap
    add_vector(32767, -32768, 'hFFFF, 'h0000, 1'b1, 0, 0);
    // Impulse of full scale reaches the second tap, weight 5
    add_vector(0, 0, 'h0000, 'hFFFF, 1'b1, 5, -5);
    add_vector(0, 0, 'h5555, 'hAAAA, 1'b0, 0, 0);
    add_vector(0, 0, 'hAAAA, 'h5555, 1'b0, 0, 0);
    add_vector(0, 0, 'h8000, 'h7FFF, 1'b0, 0, 0);
    add_vector(0, 0, 'h7FFF, 'h8000, 1'b0, 0, 0);
    add_vector(-1, 1, 'h0001, 'hFFFE, 1'b0, 0, 0);
    add_vector(1, -1, 'hFFFE, 'h0001, 1'b0, 0, 0);
    add_vector(21845, -21846, 'h5555, 'h5555, 1'b0, 0, 0);
    add_vector(-21846, 21845, 'hAAAA, 'hAAAA, 1'b0, 0, 0);
    add_vector(-32768, 32767, 'h0000, 'h0000, 1'b0, 0, 0);
    // Full-scale toggle sits in the stop band
    for (int i = 0; i < 8; i++) begin
      add_vector(i % 2 ? 32767 : -32768, i % 2 ? -32768 : 32767,
                 'hFFFF, 'hFFFF, 1'b0, 0, 0);
    end
    for (int i = 0; i < 5; i++) begin
      add_vector(32767, -32768, 'h1234, 'hFEDC, 1'b0, 0, 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (vectors[k]) begin
      send_beat(vectors[k].beat);
      guess = filter_beat(vectors[k].beat);
      if (vectors[k].typed) begin
        guess.red_filtered = vectors[k].red_want;
        guess.ir_filtered  = vectors[k].ir_want;
      end
      filtered_due.push_back(guess);
    end

    // Random segments of one shape each; hold segments fill the whole line
    seg_left = 0;
    sent     = 0;
    while (sent < RANDOM_BEATS) begin
      if (seg_left == 0) begin
        shape    = shape_e'($urandom_range(0, SHAPE_COUNT - 1));
        seg_left = (shape == SHAPE_HOLD_MAX || shape == SHAPE_HOLD_MIN) ?
                   $urandom_range(TAPS, 2 * TAPS) : $urandom_range(1, 120);
        tx_calm  = ($urandom_range(0, 3) == 0);
      end
      // Hold off once midway until every pending beat has come out
      if (sent == RANDOM_BEATS / 2) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (filtered_due.size() != 0);
      end
      b.red_ac_sample = pick_sample(shape, sent, 1'b0);
      b.ir_ac_sample  = pick_sample(shape, sent, $urandom_range(0, 1) == 1);
      b.red_dc_level  = 16'($urandom_range(0, 65535));
      b.ir_dc_level   = 16'($urandom_range(0, 65535));
      send_beat(b);
      filtered_due.push_back(filter_beat(b));
      sent++;
      seg_left--;
    end
    in_if.valid <= 1'b0;

    // Drain, then watch a little longer for stray beats
    while (filtered_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && filtered_due.size() == 0) begin
      $display("dual_channel_fir_lowpass verification clean");
    end else begin
      $display("dual_channel_fir_lowpass verification failed");
    end
    $finish;
  end

  // Output side: stall at random, with calm stretches
  initial begin : drain_side
    int stall;
    bit rx_calm;
    rx_calm = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && rst_ni));
    end
  end

  // Compare each output beat with the oldest pending one
  always @(posedge clk_i) begin : check_outputs
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (filtered_due.size() == 0) begin
        note_mismatch("unexpected beat", 'x, out_if.data.red_filtered);
      end else begin
        want = filtered_due.pop_front();
        if (out_if.data.red_filtered !== want.red_filtered)
          note_mismatch("red_filtered", want.red_filtered, out_if.data.red_filtered);
        if (out_if.data.ir_filtered !== want.ir_filtered)
          note_mismatch("ir_filtered", want.ir_filtered, out_if.data.ir_filtered);
        if (out_if.data.red_dc_out !== want.red_dc_out)
          note_mismatch("red_dc_out", want.red_dc_out, out_if.data.red_dc_out);
        if (out_if.data.ir_dc_out !== want.ir_dc_out)
          note_mismatch("ir_dc_out", want.ir_dc_out, out_if.data.ir_dc_out);
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("dual_channel_fir_lowpass verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
